### hdl/nta_pkg.sv
`timescale 1ns / 1ps

package nta_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int MAC_W      = 48;
   localparam int IP_W       = 32;
   localparam int TIME_W     = 32;
   localparam int AGE_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int OUT_CNT_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // one stored entry: {mac, ip, last seen}
   localparam int ENTRY_W  = MAC_W + IP_W + TIME_W;
   localparam int SEEN_LSB = 0;
   localparam int IP_LSB   = TIME_W;
   localparam int MAC_LSB  = TIME_W + IP_W;

   // reset values of the aging registers
   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET      = 8'd30;
   localparam logic [AGE_W-1:0] SWEEP_INTERVAL_RESET = 8'd5;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_SUBNET     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_INTERVAL = 2'd3;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED      = 3'd0,
      ST_REFRESHED  = 3'd1,
      ST_IP_CHANGED = 3'd2,
      ST_OWN_IP     = 3'd3,
      ST_FOREIGN    = 3'd4,
      ST_FULL       = 3'd5,
      ST_TICK       = 3'd6
   } status_type;

endpackage

### hdl/nta_ram.sv
`timescale 1ns / 1ps

module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/neighbor_table_with_aging_core.sv
`timescale 1ns / 1ps

// Neighbor table keyed by MAC address, with aging of stale entries.
// Request channel (req_*): one word is an announcement (req_mode 0) or a
// one-second tick (req_mode 1); it is taken when req_valid is high and
// req_stall is low. Response channel (rsp_*): exactly one word per request,
// taken when rsp_valid is high and rsp_stall is low.
// Control port (csr_*): csr_ready is always high; write only while idle.
// Sequencing: an announcement, and a tick that sweeps, walks all ENTRIES
// slots of the entry RAM one read per cycle, then passes through the drain,
// decide and finish states; the finish state writes the response into the
// output register. A tick that does not sweep goes straight to the finish
// state. The single RAM read port is why the slots are read one at a time.
// req_stall stays high while a request is in progress.
// A stalled response is held in its output register; a finished request may
// be followed by a new one, but the next response waits until the held word
// is taken.
// Reset (synchronous, active high) clears all valid bits at once, the second
// counter and sweep countdown, and loads the register defaults; there is no
// clearing pass.

module neighbor_table_with_aging_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [nta_pkg::MAC_W-1:0]         req_mac,
   input  logic [nta_pkg::IP_W-1:0]          req_ip,
   input  logic [nta_pkg::IP_W-1:0]          req_source_ip,
   input  logic [nta_pkg::IP_W-1:0]          req_subnet,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nta_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_conflict,
   output logic                              rsp_mismatch,
   output logic [nta_pkg::OUT_CNT_W-1:0]     rsp_ip_users,
   output logic [nta_pkg::OUT_CNT_W-1:0]     rsp_removed_count,
   output logic [nta_pkg::OUT_CNT_W-1:0]     rsp_occupancy,
   // control port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nta_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_FINISH
   } state_type;

   localparam logic [nta_pkg::IDX_W-1:0] LAST_IDX = nta_pkg::IDX_W'(nta_pkg::ENTRIES - 1);

   // sequencer and table state
   state_type                          state_ff, state_in;
   logic [nta_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [nta_pkg::IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [nta_pkg::ENTRIES-1:0]        valid_ff, valid_in;
   logic [nta_pkg::CNT_W-1:0]          occ_ff, occ_in;
   logic [nta_pkg::TIME_W-1:0]         seconds_ff, seconds_in;
   logic [nta_pkg::AGE_W-1:0]          countdown_ff, countdown_in;

   // control registers
   logic [nta_pkg::IP_W-1:0]           own_ip_ff, own_ip_in;
   logic [nta_pkg::IP_W-1:0]           own_subnet_ff, own_subnet_in;
   logic [nta_pkg::AGE_W-1:0]          age_limit_ff, age_limit_in;
   logic [nta_pkg::AGE_W-1:0]          sweep_ivl_ff, sweep_ivl_in;

   // latched request word
   logic                               tick_ff, tick_in;
   logic [nta_pkg::MAC_W-1:0]          mac_ff, mac_in;
   logic [nta_pkg::IP_W-1:0]           ip_ff, ip_in;
   logic [nta_pkg::IP_W-1:0]           sender_ff, sender_in;
   logic [nta_pkg::IP_W-1:0]           subnet_ff, subnet_in;

   // scan accumulators
   logic                               hit_ff, hit_in;
   logic [nta_pkg::IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic                               hit_ipdiff_ff, hit_ipdiff_in;
   logic                               free_ff, free_in;
   logic [nta_pkg::IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [nta_pkg::CNT_W-1:0]          users_ff, users_in;
   logic [nta_pkg::CNT_W-1:0]          removed_ff, removed_in;

   // step result, then output register
   nta_pkg::status_type                res_status_ff, res_status_in;
   logic                               res_conflict_ff, res_conflict_in;
   logic                               res_mismatch_ff, res_mismatch_in;
   logic [nta_pkg::CNT_W-1:0]          res_users_ff, res_users_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [nta_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                               rsp_conflict_ff, rsp_conflict_in;
   logic                               rsp_mismatch_ff, rsp_mismatch_in;
   logic [nta_pkg::OUT_CNT_W-1:0]      rsp_users_ff, rsp_users_in;
   logic [nta_pkg::OUT_CNT_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [nta_pkg::OUT_CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;

   // entry RAM ports
   logic                               ram_we;
   logic [nta_pkg::IDX_W-1:0]          ram_waddr;
   logic [nta_pkg::ENTRY_W-1:0]        ram_wdata;
   logic [nta_pkg::ENTRY_W-1:0]        ram_rdata;

   logic [nta_pkg::MAC_W-1:0]          ent_mac;
   logic [nta_pkg::IP_W-1:0]           ent_ip;
   logic [nta_pkg::TIME_W-1:0]         ent_seen;
   logic                               ent_valid;
   logic [nta_pkg::CNT_W-1:0]          users_new;

   nta_ram #(
      .WIDTH (nta_pkg::ENTRY_W),
      .DEPTH (nta_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // split the word read back for the slot under test
   assign ent_mac   = ram_rdata[nta_pkg::MAC_LSB +: nta_pkg::MAC_W];
   assign ent_ip    = ram_rdata[nta_pkg::IP_LSB +: nta_pkg::IP_W];
   assign ent_seen  = ram_rdata[nta_pkg::SEEN_LSB +: nta_pkg::TIME_W];
   assign ent_valid = valid_ff[rd_idx_ff];

   assign ram_wdata = {mac_ff, ip_ff, seconds_ff};

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = idx_ff;
      valid_in        = valid_ff;
      occ_in          = occ_ff;
      seconds_in      = seconds_ff;
      countdown_in    = countdown_ff;
      own_ip_in       = own_ip_ff;
      own_subnet_in   = own_subnet_ff;
      age_limit_in    = age_limit_ff;
      sweep_ivl_in    = sweep_ivl_ff;
      tick_in         = tick_ff;
      mac_in          = mac_ff;
      ip_in           = ip_ff;
      sender_in       = sender_ff;
      subnet_in       = subnet_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_ipdiff_in   = hit_ipdiff_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      users_in        = users_ff;
      removed_in      = removed_ff;
      res_status_in   = res_status_ff;
      res_conflict_in = res_conflict_ff;
      res_mismatch_in = res_mismatch_ff;
      res_users_in    = res_users_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_mismatch_in = rsp_mismatch_ff;
      rsp_users_in    = rsp_users_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_occ_in      = rsp_occ_ff;
      ram_we          = 1'b0;
      ram_waddr       = hit_ff ? hit_idx_ff : free_idx_ff;
      users_new       = users_ff;

      // take control register writes
      if (csr_valid) begin
         unique case (csr_index)
            nta_pkg::CSR_OWN_IP:         own_ip_in     = csr_wdata;
            nta_pkg::CSR_OWN_SUBNET:     own_subnet_in = csr_wdata;
            nta_pkg::CSR_AGE_LIMIT:      age_limit_in  = csr_wdata[nta_pkg::AGE_W-1:0];
            nta_pkg::CSR_SWEEP_INTERVAL: sweep_ivl_in  = csr_wdata[nta_pkg::AGE_W-1:0];
         endcase
      end

      // drop the response word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // evaluate the slot read back from the RAM
      if (rd_vld_ff) begin
         if (tick_ff) begin
            if (ent_valid && ((seconds_ff - ent_seen) > nta_pkg::TIME_W'(age_limit_ff))) begin
               valid_in[rd_idx_ff] = 1'b0;
               removed_in          = removed_ff + 1'b1;
               occ_in              = occ_ff - 1'b1;
            end
         end else if (ent_valid) begin
            if (!hit_ff && ent_mac == mac_ff) begin
               hit_in        = 1'b1;
               hit_idx_in    = rd_idx_ff;
               hit_ipdiff_in = (ent_ip != ip_ff);
            end
            if (ent_ip == ip_ff) begin
               users_in = users_ff + 1'b1;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tick_in         = req_mode;
               mac_in          = req_mac;
               ip_in           = req_ip;
               sender_in       = req_source_ip;
               subnet_in       = req_subnet;
               hit_in          = 1'b0;
               free_in         = 1'b0;
               users_in        = '0;
               removed_in      = '0;
               idx_in          = '0;
               res_status_in   = nta_pkg::ST_TICK;
               res_conflict_in = 1'b0;
               res_mismatch_in = 1'b0;
               res_users_in    = '0;
               state_in        = S_SCAN;
               if (req_mode) begin
                  seconds_in = seconds_ff + 1'b1;
                  if (countdown_ff <= 8'd1) begin
                     countdown_in = sweep_ivl_ff;
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                     state_in     = S_FINISH;
                  end
               end
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            idx_in    = nta_pkg::IDX_W'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!tick_ff) begin
               if (subnet_ff != own_subnet_ff) begin
                  res_status_in = nta_pkg::ST_FOREIGN;
               end else if (ip_ff == own_ip_ff) begin
                  res_status_in = nta_pkg::ST_OWN_IP;
               end else if (hit_ff) begin
                  ram_we = 1'b1;
                  if (hit_ipdiff_ff) begin
                     res_status_in   = nta_pkg::ST_IP_CHANGED;
                     users_new       = users_ff + 1'b1;
                     res_conflict_in = (users_new > nta_pkg::CNT_W'(1));
                     res_mismatch_in = (ip_ff != sender_ff);
                  end else begin
                     res_status_in = nta_pkg::ST_REFRESHED;
                  end
               end else if (free_ff) begin
                  ram_we                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  occ_in                = occ_ff + 1'b1;
                  res_status_in         = nta_pkg::ST_ADDED;
                  users_new             = users_ff + 1'b1;
                  res_conflict_in       = (users_new > nta_pkg::CNT_W'(1));
                  res_mismatch_in       = (ip_ff != sender_ff);
               end else begin
                  res_status_in = nta_pkg::ST_FULL;
               end
               res_users_in = users_new;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_conflict_in = res_conflict_ff;
               rsp_mismatch_in = res_mismatch_ff;
               rsp_users_in    = nta_pkg::OUT_CNT_W'(res_users_ff);
               rsp_removed_in  = nta_pkg::OUT_CNT_W'(removed_ff);
               rsp_occ_in      = nta_pkg::OUT_CNT_W'(occ_ff);
               state_in        = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         seconds_ff    <= '0;
         countdown_ff  <= '0;
         own_ip_ff     <= '0;
         own_subnet_ff <= '0;
         age_limit_ff  <= nta_pkg::AGE_LIMIT_RESET;
         sweep_ivl_ff  <= nta_pkg::SWEEP_INTERVAL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         seconds_ff    <= seconds_in;
         countdown_ff  <= countdown_in;
         own_ip_ff     <= own_ip_in;
         own_subnet_ff <= own_subnet_in;
         age_limit_ff  <= age_limit_in;
         sweep_ivl_ff  <= sweep_ivl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff       <= rd_idx_in;
      tick_ff         <= tick_in;
      mac_ff          <= mac_in;
      ip_ff           <= ip_in;
      sender_ff       <= sender_in;
      subnet_ff       <= subnet_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      hit_ipdiff_ff   <= hit_ipdiff_in;
      free_ff         <= free_in;
      free_idx_ff     <= free_idx_in;
      users_ff        <= users_in;
      removed_ff      <= removed_in;
      res_status_ff   <= res_status_in;
      res_conflict_ff <= res_conflict_in;
      res_mismatch_ff <= res_mismatch_in;
      res_users_ff    <= res_users_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_mismatch_ff <= rsp_mismatch_in;
      rsp_users_ff    <= rsp_users_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_occ_ff      <= rsp_occ_in;
   end

   // drive the ports
   assign req_stall         = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_conflict      = rsp_conflict_ff;
   assign rsp_mismatch      = rsp_mismatch_ff;
   assign rsp_ip_users      = rsp_users_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_occupancy     = rsp_occ_ff;

`ifndef SYNTH
   // occupancy counter tracks the valid bits
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      occ_ff == nta_pkg::CNT_W'($countones(valid_ff)))
      else $error("occupancy counter out of step with valid bits");

   // a request holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in progress");

   // flags appear only on an add or an ip change
   a_flags_on_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_conflict || rsp_mismatch)) |->
      (rsp_status == nta_pkg::ST_ADDED || rsp_status == nta_pkg::ST_IP_CHANGED))
      else $error("conflict or mismatch flagged outside an update");

   // removals are reported only by ticks
   a_removed_on_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != nta_pkg::ST_TICK) |-> (rsp_removed_count == '0))
      else $error("removed count on an announcement");
`endif

endmodule

### dv/neighbor_table_with_aging_core_tb.sv
`timescale 1ns / 1ps

module neighbor_table_with_aging_core_tb;

   import nta_pkg::*;

   localparam int CLOCK_HALF_NS = 2;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int SETTLE_CYCLES = 2 * ENTRIES;
   localparam int MAC_POOL      = 20;
   localparam int IP_POOL       = 6;

   typedef struct {
      logic             mode;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  ip;
      logic [IP_W-1:0]  source_ip;
      logic [IP_W-1:0]  subnet;
   } neighbor_req_t;

   typedef struct {
      status_type           status;
      logic                 conflict;
      logic                 mismatch;
      logic [OUT_CNT_W-1:0] ip_users;
      logic [OUT_CNT_W-1:0] removed_count;
      logic [OUT_CNT_W-1:0] occupancy;
   } neighbor_rsp_t;

   // Mirror of the table: predicts one result word per accepted request word
   class neighbor_scoreboard;
      logic [IP_W-1:0]   own_ip;
      logic [IP_W-1:0]   own_subnet;
      logic [AGE_W-1:0]  age_limit;
      logic [AGE_W-1:0]  sweep_interval;

      bit                slot_used [ENTRIES];
      logic [MAC_W-1:0]  slot_mac  [ENTRIES];
      logic [IP_W-1:0]   slot_ip   [ENTRIES];
      logic [TIME_W-1:0] slot_seen [ENTRIES];
      logic [TIME_W-1:0] seconds;
      logic [AGE_W-1:0]  countdown;

      neighbor_rsp_t awaited_results[$];
      int errors;
      int checked;
      int status_count[8];
      int aged_out;
      int peak_occupancy;
      int conflicts;
      int mismatches;

      function new();
         own_ip         = '0;
         own_subnet     = '0;
         age_limit      = AGE_LIMIT_RESET;
         sweep_interval = SWEEP_INTERVAL_RESET;
         seconds        = '0;
         countdown      = '0;
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_mac[i]  = '0;
            slot_ip[i]   = '0;
            slot_seen[i] = '0;
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_OWN_IP:         own_ip = data;
            CSR_OWN_SUBNET:     own_subnet = data;
            CSR_AGE_LIMIT:      age_limit = data[AGE_W-1:0];
            CSR_SWEEP_INTERVAL: sweep_interval = data[AGE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Apply one request word to the mirror and queue the result it should give
      function void take_request(neighbor_req_t w);
         neighbor_rsp_t r;
         int hit;
         int free_slot;
         int users;
         int removed;
         int used;
         bit flagged;
         logic [TIME_W-1:0] age;

         r.status = ST_TICK;
         r.conflict = 1'b0;
         r.mismatch = 1'b0;
         users = 0;
         removed = 0;
         used = 0;
         flagged = 1'b0;

         if (w.mode) begin
            // advance the clock, sweep when the countdown runs out
            seconds = seconds + 1;
            if (countdown <= 1) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  age = seconds - slot_seen[i];
                  if (slot_used[i] && age > {24'd0, age_limit}) begin
                     slot_used[i] = 1'b0;
                     removed++;
                  end
               end
               countdown = sweep_interval;
            end else begin
               countdown = countdown - 1;
            end
         end else begin
            if (w.subnet != own_subnet) begin
               r.status = ST_FOREIGN;
            end else if (w.ip == own_ip) begin
               r.status = ST_OWN_IP;
            end else begin
               // look up the MAC and the lowest free slot
               hit = -1;
               free_slot = -1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_used[i]) begin
                     if (hit < 0 && slot_mac[i] == w.mac) hit = i;
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (hit >= 0) begin
                  if (slot_ip[hit] != w.ip) begin
                     slot_ip[hit] = w.ip;
                     r.status = ST_IP_CHANGED;
                     flagged = 1'b1;
                  end else begin
                     r.status = ST_REFRESHED;
                  end
                  slot_seen[hit] = seconds;
               end else if (free_slot >= 0) begin
                  slot_used[free_slot] = 1'b1;
                  slot_mac[free_slot]  = w.mac;
                  slot_ip[free_slot]   = w.ip;
                  slot_seen[free_slot] = seconds;
                  r.status = ST_ADDED;
                  flagged = 1'b1;
               end else begin
                  r.status = ST_FULL;
               end
            end
            for (int i = 0; i < ENTRIES; i++)
               if (slot_used[i] && slot_ip[i] == w.ip) users++;
            if (flagged) begin
               r.conflict = (users > 1);
               r.mismatch = (w.ip != w.source_ip);
            end
         end

         foreach (slot_used[i]) if (slot_used[i]) used++;
         r.ip_users      = OUT_CNT_W'(users);
         r.removed_count = OUT_CNT_W'(removed);
         r.occupancy     = OUT_CNT_W'(used);
         awaited_results.push_back(r);

         // keep run statistics
         status_count[int'(r.status)]++;
         aged_out += removed;
         if (used > peak_occupancy) peak_occupancy = used;
         if (r.conflict) conflicts++;
         if (r.mismatch) mismatches++;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      // Compare one result word against the oldest prediction
      function void check_result(neighbor_rsp_t got);
         neighbor_rsp_t want;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: result word expected none, got status %0d occupancy %0d",
                     $time, got.status, got.occupancy);
            return;
         end
         want = awaited_results.pop_front();
         checked++;
         compare_field("status", want.status, got.status);
         compare_field("conflict", want.conflict, got.conflict);
         compare_field("mismatch", want.mismatch, got.mismatch);
         compare_field("ip_users", want.ip_users, got.ip_users);
         compare_field("removed_count", want.removed_count, got.removed_count);
         compare_field("occupancy", want.occupancy, got.occupancy);
      endfunction
   endclass

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_mode      = 1'b0;
   logic [MAC_W-1:0]      req_mac       = '0;
   logic [IP_W-1:0]       req_ip        = '0;
   logic [IP_W-1:0]       req_source_ip = '0;
   logic [IP_W-1:0]       req_subnet    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_conflict;
   logic                  rsp_mismatch;
   logic [OUT_CNT_W-1:0]  rsp_ip_users;
   logic [OUT_CNT_W-1:0]  rsp_removed_count;
   logic [OUT_CNT_W-1:0]  rsp_occupancy;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   int idle_pct = 20;
   neighbor_scoreboard sb;

   neighbor_table_with_aging_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_mac           (req_mac),
      .req_ip            (req_ip),
      .req_source_ip     (req_source_ip),
      .req_subnet        (req_subnet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_conflict      (rsp_conflict),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_ip_users      (rsp_ip_users),
      .rsp_removed_count (rsp_removed_count),
      .rsp_occupancy     (rsp_occupancy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin : watch
      neighbor_req_t w;
      neighbor_rsp_t g;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            w.mode      = req_mode;
            w.mac       = req_mac;
            w.ip        = req_ip;
            w.source_ip = req_source_ip;
            w.subnet    = req_subnet;
            sb.take_request(w);
         end
         if (rsp_valid && !rsp_stall) begin
            g.status        = status_type'(rsp_status);
            g.conflict      = rsp_conflict;
            g.mismatch      = rsp_mismatch;
            g.ip_users      = rsp_ip_users;
            g.removed_count = rsp_removed_count;
            g.occupancy     = rsp_occupancy;
            sb.check_result(g);
         end
      end
   end

   // Present one request word, with an optional gap, and hold it until taken
   task automatic send_word(input neighbor_req_t w);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= w.mode;
      req_mac       <= w.mac;
      req_ip        <= w.ip;
      req_source_ip <= w.source_ip;
      req_subnet    <= w.subnet;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_announce(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                                input logic [IP_W-1:0] sender, input logic [IP_W-1:0] subnet);
      neighbor_req_t w;
      w.mode = 1'b0;
      w.mac = mac;
      w.ip = ip;
      w.source_ip = sender;
      w.subnet = subnet;
      send_word(w);
   endtask

   // Tick with junk in the ignored fields
   task automatic send_tick();
      neighbor_req_t w;
      w.mode = 1'b1;
      w.mac = MAC_W'({$urandom, $urandom});
      w.ip = $urandom;
      w.source_ip = $urandom;
      w.subnet = $urandom;
      send_word(w);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reconfigure while idle, then stream mostly well-formed announcements
   task automatic run_phase(input logic [IP_W-1:0] ip_v, input logic [IP_W-1:0] subnet_v,
                            input logic [AGE_W-1:0] age_v, input logic [AGE_W-1:0] sweep_v,
                            input int pct, input int count);
      logic [MAC_W-1:0] mac_pool [MAC_POOL];
      logic [IP_W-1:0]  ip_pool  [IP_POOL];
      logic [IP_W-1:0]  last_ip  [MAC_POOL];
      neighbor_req_t w;
      int pick;
      int k;

      drain();
      write_reg(CSR_OWN_IP, ip_v);
      write_reg(CSR_OWN_SUBNET, subnet_v);
      write_reg(CSR_AGE_LIMIT, CSR_DATA_W'(age_v));
      write_reg(CSR_SWEEP_INTERVAL, CSR_DATA_W'(sweep_v));
      idle_pct = pct;

      foreach (ip_pool[i]) ip_pool[i] = $urandom;
      foreach (mac_pool[i]) begin
         mac_pool[i] = MAC_W'({$urandom, $urandom});
         last_ip[i]  = ip_pool[$urandom_range(IP_POOL - 1)];
      end

      repeat (count) begin
         pick = $urandom_range(99);
         w.mode      = 1'b0;
         w.mac       = MAC_W'({$urandom, $urandom});
         w.ip        = $urandom;
         w.source_ip = $urandom;
         w.subnet    = $urandom;
         if (pick < 22) begin
            w.mode = 1'b1;
         end else if (pick < 27) begin
            // noise: leave everything random
         end else if (pick < 31) begin
            w.subnet = subnet_v;
            w.ip = ip_v;
         end else if (pick < 35) begin
            w.subnet = subnet_v ^ (32'h1 << $urandom_range(31));
         end else begin
            // known neighbor: usually same IP again, sometimes a move
            k = $urandom_range(MAC_POOL - 1);
            if ($urandom_range(99) < 40) last_ip[k] = ip_pool[$urandom_range(IP_POOL - 1)];
            w.mac = mac_pool[k];
            w.ip = last_ip[k];
            w.subnet = subnet_v;
            if ($urandom_range(99) < 75) w.source_ip = w.ip;
         end
         send_word(w);
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed checks against the reset register values
      send_tick();
      send_announce(48'h1, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_announce(48'h1, 32'h0, 32'h0, 32'h0);
      send_announce(48'h0, 32'h1, 32'h1, 32'h0);
      send_announce(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_announce(48'h0, 32'h1, 32'h1, 32'h0);
      send_announce(48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      for (int i = 2; i < ENTRIES; i++)
         send_announce(48'h100 + i, 32'h0A00_0000 + i, 32'h0A00_0000 + i, 32'h0);
      send_announce(48'h5555_5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h0);
      send_announce(48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF, 32'h5555_5555, 32'h0);
      send_tick();

      // Random phases across register settings, one without any idling
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 8'd1, 20, 200);
      run_phase($urandom, 32'h0, 8'd255, 8'd255, 20, 200);
      run_phase($urandom, $urandom, 8'd8, 8'd2, 0, 200);
      run_phase($urandom, $urandom, AGE_W'($urandom_range(1, 255)), 8'd3, 20, 200);
      run_phase(32'h0, $urandom, 8'd4, 8'd1, 20, 200);
      drain();

      $display("Checked %0d words: %0d added, %0d refreshed, %0d moved, %0d own-ip,",
               sb.checked, sb.status_count[ST_ADDED], sb.status_count[ST_REFRESHED],
               sb.status_count[ST_IP_CHANGED], sb.status_count[ST_OWN_IP]);
      $display("  %0d foreign, %0d full, %0d ticks, %0d aged out, peak occupancy %0d,",
               sb.status_count[ST_FOREIGN], sb.status_count[ST_FULL],
               sb.status_count[ST_TICK], sb.aged_out, sb.peak_occupancy);
      $display("  %0d conflicts, %0d mismatches", sb.conflicts, sb.mismatches);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
